// ===== design/tfct_pkg.sv =====
// types and constants shared by the tcp flow counter table
// no dependencies
package tfct_pkg;

  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [7:0]  ProtoTcp      = 8'h06;
  localparam logic [15:0] MinFrameBytes = 16'd54;

  typedef enum logic [1:0] {
    StIgnored  = 2'd0,
    StInserted = 2'd1,
    StUpdated  = 2'd2,
    StFull     = 2'd3
  } status_e;

  typedef struct packed {
    logic [15:0] frame_length;
    logic [15:0] ethertype;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] flow_bytes;
    logic [63:0] flow_packets;
  } result_t;

  typedef struct packed {
    logic        valid;
    logic        done;
    logic        hit;
    logic [95:0] key;
    logic [15:0] len;
    logic [63:0] bytes;
    logic [63:0] pkts;
  } probe_t;

endpackage

// ===== design/tfct_cell.sv =====
// one table entry: key, valid mark and counters, passing the probe on
// depends on tfct_pkg
module tfct_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tfct_pkg::probe_t probe_i,
  output tfct_pkg::probe_t probe_o
);

  logic        ent_valid_q, ent_valid_d;
  logic [95:0] key_q, key_d;
  logic [63:0] bytes_q, bytes_d;
  logic [63:0] pkts_q, pkts_d;
  tfct_pkg::probe_t probe_d, probe_q;
  logic        live;

  always_comb begin
    live        = probe_i.valid && !probe_i.done;
    ent_valid_d = ent_valid_q;
    key_d       = key_q;
    bytes_d     = bytes_q;
    pkts_d      = pkts_q;
    probe_d     = probe_i;
    if (live) begin
      if (ent_valid_q) begin
        if (key_q == probe_i.key) begin
          bytes_d       = bytes_q + {48'd0, probe_i.len};
          pkts_d        = pkts_q + 64'd1;
          probe_d.done  = 1'b1;
          probe_d.hit   = 1'b1;
          probe_d.bytes = bytes_d;
          probe_d.pkts  = pkts_d;
        end
      end else begin
        // valid entries form a prefix, so the first free one ends the search
        ent_valid_d   = 1'b1;
        key_d         = probe_i.key;
        bytes_d       = 64'd0;
        pkts_d        = 64'd0;
        probe_d.done  = 1'b1;
        probe_d.hit   = 1'b0;
        probe_d.bytes = 64'd0;
        probe_d.pkts  = 64'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= 1'b0;
      probe_q     <= '0;
    end else begin
      ent_valid_q <= ent_valid_d;
      probe_q     <= probe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    bytes_q <= bytes_d;
    pkts_q  <= pkts_d;
  end

  assign probe_o = probe_q;

endmodule

// ===== design/tcp_flow_counter_table_unit.sv =====
// tcp flow counter table: filter, row of entry cells and result register
// depends on tfct_pkg and tfct_cell
// a counted frame walks the row one cell per cycle; its result is registered after it leaves the last cell
// an ignored frame gives its result in the cycle after start and leaves busy low
// busy stays high while a counted frame is in the row; reset empties the table at once, the
// receiver cannot stall
module tcp_flow_counter_table_unit #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  tfct_pkg::item_t   item_i,
  output logic              done_o,
  output tfct_pkg::result_t result_o
);

  tfct_pkg::probe_t probe [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES:0] chain_valid;
  logic accept, counted;
  logic busy_q, busy_d;
  logic done_q, done_d;
  tfct_pkg::result_t result_q, result_d;

  assign accept  = start && !busy_q;
  assign counted = item_i.frame_length >= tfct_pkg::MinFrameBytes
                && item_i.ethertype == tfct_pkg::EtherTypeIpv4
                && item_i.ip_protocol == tfct_pkg::ProtoTcp;

  always_comb begin
    probe[0].valid = accept && counted;
    probe[0].done  = 1'b0;
    probe[0].hit   = 1'b0;
    probe[0].key   = {item_i.source_address, item_i.destination_address,
                      item_i.source_port, item_i.destination_port};
    probe[0].len   = item_i.frame_length;
    probe[0].bytes = 64'd0;
    probe[0].pkts  = 64'd0;
  end

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    tfct_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .probe_i (probe[k]),
      .probe_o (probe[k+1])
    );
  end

  for (genvar k = 0; k <= TABLE_ENTRIES; k++) begin : g_vld
    assign chain_valid[k] = probe[k].valid;
  end

  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    result_d = result_q;
    if (probe[TABLE_ENTRIES].valid) begin
      busy_d   = 1'b0;
      done_d   = 1'b1;
      result_d.flow_bytes   = probe[TABLE_ENTRIES].bytes;
      result_d.flow_packets = probe[TABLE_ENTRIES].pkts;
      if (!probe[TABLE_ENTRIES].done) begin
        result_d.status = tfct_pkg::StFull;
      end else if (probe[TABLE_ENTRIES].hit) begin
        result_d.status = tfct_pkg::StUpdated;
      end else begin
        result_d.status = tfct_pkg::StInserted;
      end
    end else if (accept) begin
      if (counted) begin
        busy_d = 1'b1;
      end else begin
        done_d   = 1'b1;
        result_d = '{status: tfct_pkg::StIgnored, flow_bytes: 64'd0, flow_packets: 64'd0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign busy     = busy_q;
  assign done_o   = done_q;
  assign result_o = result_q;

`ifndef SYNTHESIS
  a_one_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(chain_valid))
    else $error("more than one transfer in the cell row");
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> chain_valid[TABLE_ENTRIES:1] == '0)
    else $error("cell row active while idle");
  a_exit_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    probe[TABLE_ENTRIES].valid |=> done_q && !busy_q)
    else $error("row exit did not produce a result");
  a_zero_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && (result_q.status == tfct_pkg::StIgnored
            || result_q.status == tfct_pkg::StInserted
            || result_q.status == tfct_pkg::StFull)
    |-> result_q.flow_bytes == 64'd0 && result_q.flow_packets == 64'd0)
    else $error("nonzero counts without an update");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking bench for the tcp flow counter table unit
// depends on tfct_pkg and the design sources; predicts every result from its own flow table
`timescale 1ns / 1ps

module tb_top;

  localparam int FlowSlots = 256;
  localparam int TargetItems = 1730;
  localparam int KeyPool = 320;
  localparam int StallLimit = 4000;
  localparam int DrainCycles = 300;

  class flow_table_board;
    logic [95:0] keys[FlowSlots];
    bit          used[FlowSlots];
    logic [63:0] bytes_cnt[FlowSlots];
    logic [63:0] pkts_cnt[FlowSlots];
    tfct_pkg::result_t awaited[$];
    int          errors;

    function new();
      errors = 0;
      foreach (used[i]) used[i] = 0;
    endfunction

    function void note_item(tfct_pkg::item_t it);
      tfct_pkg::result_t r;
      logic [95:0] k;
      int          hit;
      int          free_idx;
      r = '0;
      r.status = tfct_pkg::StIgnored;
      hit = -1;
      free_idx = -1;
      k = {it.source_address, it.destination_address, it.source_port,
           it.destination_port};
      if (it.frame_length >= tfct_pkg::MinFrameBytes &&
          it.ethertype == tfct_pkg::EtherTypeIpv4 &&
          it.ip_protocol == tfct_pkg::ProtoTcp) begin
        for (int i = 0; i < FlowSlots; i++) begin
          if (used[i]) begin
            if (hit < 0 && keys[i] == k) hit = i;
          end else if (free_idx < 0) begin
            free_idx = i;
          end
        end
        if (hit >= 0) begin
          bytes_cnt[hit] = bytes_cnt[hit] + 64'(it.frame_length);
          pkts_cnt[hit] = pkts_cnt[hit] + 64'd1;
          r.status = tfct_pkg::StUpdated;
          r.flow_bytes = bytes_cnt[hit];
          r.flow_packets = pkts_cnt[hit];
        end else if (free_idx >= 0) begin
          used[free_idx] = 1;
          keys[free_idx] = k;
          bytes_cnt[free_idx] = '0;
          pkts_cnt[free_idx] = '0;
          r.status = tfct_pkg::StInserted;
        end else begin
          r.status = tfct_pkg::StFull;
        end
      end
      awaited.push_back(r);
    endfunction

    function void check_result(tfct_pkg::result_t got);
      tfct_pkg::result_t exp_r;
      if (awaited.size() == 0) begin
        $error("result with nothing awaited: status %0d", got.status);
        errors++;
        return;
      end
      exp_r = awaited.pop_front();
      if (got.status !== exp_r.status) begin
        $error("status expected %0d actual %0d", exp_r.status, got.status);
        errors++;
      end
      if (got.flow_bytes !== exp_r.flow_bytes) begin
        $error("flow_bytes expected %0d actual %0d", exp_r.flow_bytes, got.flow_bytes);
        errors++;
      end
      if (got.flow_packets !== exp_r.flow_packets) begin
        $error("flow_packets expected %0d actual %0d", exp_r.flow_packets,
               got.flow_packets);
        errors++;
      end
    endfunction
  endclass

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  tfct_pkg::item_t   item_i = '0;
  logic    done_o;
  tfct_pkg::result_t result_o;

  flow_table_board board = new();
  logic [95:0] pool[KeyPool];
  int          idle_cycles = 0;
  bit          quiet_tail = 0;

  tcp_flow_counter_table_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) board.check_result(result_o);
  end

  // stall watchdog
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("tcp_flow_counter_table_unit regression: fail");
      $finish;
    end
  end

  function automatic tfct_pkg::item_t tcp_item(logic [15:0] len, logic [95:0] k);
    tfct_pkg::item_t it;
    it.frame_length = len;
    it.ethertype = tfct_pkg::EtherTypeIpv4;
    it.ip_protocol = tfct_pkg::ProtoTcp;
    {it.source_address, it.destination_address, it.source_port,
     it.destination_port} = k;
    return it;
  endfunction

  task automatic send(tfct_pkg::item_t it);
    int gap;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    board.note_item(it);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    tfct_pkg::item_t it;
    logic [95:0] k0;
    int          sent;
    k0 = {$urandom(), $urandom(), $urandom()};
    foreach (pool[i]) pool[i] = {$urandom(), $urandom(), $urandom()};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: filter edges, insert, update, key extremes
    it = tcp_item(16'd53, k0);                 send(it);
    it = tcp_item(16'd0, k0);                  send(it);
    it = tcp_item(16'hFFFF, k0);
    it.ethertype = 16'hFFFF;                   send(it);
    it = tcp_item(16'd100, k0);
    it.ethertype = 16'h0000;                   send(it);
    it = tcp_item(16'd100, k0);
    it.ip_protocol = 8'h07;                    send(it);
    it = tcp_item(16'd100, k0);
    it.ip_protocol = 8'hFF;                    send(it);
    it = tcp_item(16'd54, k0);                 send(it);
    it = tcp_item(16'd54, k0);                 send(it);
    it = tcp_item(16'hFFFF, k0);               send(it);
    it = tcp_item(16'd53, k0);                 send(it);
    it = tcp_item(16'd54, '0);                 send(it);
    it = tcp_item(16'd1500, '0);               send(it);
    it = tcp_item(16'd54, '1);                 send(it);
    it = tcp_item(16'hFFFF, '1);               send(it);
    it = tcp_item(16'd60, k0 ^ 96'h1);         send(it);
    it = tcp_item(16'd60, k0 ^ {32'h1, 64'h0}); send(it);
    it = tcp_item(16'd60, k0 ^ {64'h0, 16'h1, 16'h0}); send(it);
    it = tcp_item(16'd60, k0);                 send(it);
    drain();

    // random: mostly well-formed tcp frames over a key pool larger than the table
    sent = 0;
    while (sent < TargetItems) begin
      quiet_tail = (sent > TargetItems - 150);
      if ($urandom_range(0, 9) < 8) begin
        it = tcp_item(16'($urandom_range(54, 65535)),
                      ($urandom_range(0, 19) == 0) ?
                      {$urandom(), $urandom(), $urandom()} :
                      pool[$urandom_range(0, KeyPool - 1)]);
        if ($urandom_range(0, 15) == 0) it.frame_length = 16'd54;
      end else begin
        it = tfct_pkg::item_t'(136'({$urandom(), $urandom(), $urandom(), $urandom(),
                                     $urandom()}));
        if ($urandom_range(0, 1) == 0) it.ethertype = tfct_pkg::EtherTypeIpv4;
        if ($urandom_range(0, 1) == 0) it.ip_protocol = tfct_pkg::ProtoTcp;
      end
      send(it);
      sent++;
      if (sent == 700) drain();
    end
    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("tcp_flow_counter_table_unit regression: pass");
    end else begin
      $display("tcp_flow_counter_table_unit regression: fail");
    end
    $finish;
  end

endmodule
